@@ rtl/hws_pkg.sv @@
// ----------------------------------------------------------------------------
// hws_pkg
// Shared types and constants for the heartbeat watchdog supervisor.
// ----------------------------------------------------------------------------
package hws_pkg;

  localparam int unsigned ClockW    = 32;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned DeadlineW = 14;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // Event codes
  typedef enum logic [1:0] {
    CMD_CHECK     = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_RESET_REQ = 2'd2,
    CMD_BOOT      = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STALL_DEADLINE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEALTHY_UPTIME = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RESETS     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_WDOG_ENABLED   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DeadlineW-1:0] StallDeadlineRst = 14'd1500;
  localparam logic [ClockW-1:0]    HealthyUptimeRst = 32'd60000;
  localparam logic [CountW-1:0]    MaxResetsRst     = 8'd3;
  localparam logic                 WdogEnabledRst   = 1'b1;

  localparam logic [CountW-1:0]    CountMax         = 8'hFF;

  typedef struct packed {
    logic [DeadlineW-1:0] stall_deadline_ms;
    logic [ClockW-1:0]    uptime_clear_ms;
    logic [CountW-1:0]    max_resets;
    logic                 watchdog_enabled;
  } cfg_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [ElapsedW-1:0] elapsed_ms;
    logic                watchdog_caused;
  } item_t;

  typedef struct packed {
    logic              pet;
    logic              stall_detected;
    logic [ClockW-1:0] stalled_for_ms;
    logic              stopped;
    logic [CountW-1:0] boot_count;
    logic              boot_loop_trip;
    logic              count_cleared;
    logic              direct_reboot;
  } result_t;

endpackage

@@ rtl/hws_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hws_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module hws_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hws_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hws_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output hws_pkg::cfg_t                 cfg_o
);

  hws_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_deadline_ms <= hws_pkg::StallDeadlineRst;
      cfg_q.uptime_clear_ms   <= hws_pkg::HealthyUptimeRst;
      cfg_q.max_resets        <= hws_pkg::MaxResetsRst;
      cfg_q.watchdog_enabled  <= hws_pkg::WdogEnabledRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hws_pkg::CFG_STALL_DEADLINE: begin
          cfg_q.stall_deadline_ms <= cfg_wdata_i[hws_pkg::DeadlineW-1:0];
        end
        hws_pkg::CFG_HEALTHY_UPTIME: begin
          cfg_q.uptime_clear_ms <= cfg_wdata_i[hws_pkg::ClockW-1:0];
        end
        hws_pkg::CFG_MAX_RESETS: begin
          cfg_q.max_resets <= cfg_wdata_i[hws_pkg::CountW-1:0];
        end
        hws_pkg::CFG_WDOG_ENABLED: begin
          cfg_q.watchdog_enabled <= cfg_wdata_i[0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/hws_in_reg.sv @@
// ----------------------------------------------------------------------------
// hws_in_reg
// Input register stage; holds one event until the core consumes it.
// ----------------------------------------------------------------------------
module hws_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  hws_pkg::item_t in_item_i,
  output logic           in_stall_o,
  input  logic           take_i,
  output logic           item_valid_o,
  output hws_pkg::item_t item_o
);

  logic           valid_q;
  hws_pkg::item_t item_q;
  logic           load;

  // Stall only when holding an event that the core cannot take this cycle
  assign in_stall_o = valid_q && !take_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/hws_core.sv @@
// ----------------------------------------------------------------------------
// hws_core
// Supervision state and the single-pass event evaluation.
// ----------------------------------------------------------------------------
module hws_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hws_pkg::cfg_t    cfg_i,
  input  logic             fire_i,
  input  hws_pkg::item_t   item_i,
  output hws_pkg::result_t result_o
);

  logic [hws_pkg::ClockW-1:0] clock_q, clock_d;
  logic [hws_pkg::ClockW-1:0] boot_time_q, boot_time_d;
  logic [hws_pkg::ClockW-1:0] progress_q, progress_d;
  logic [hws_pkg::ClockW-1:0] hb_count_q, hb_count_d;
  logic [hws_pkg::ClockW-1:0] seen_hb_q, seen_hb_d;
  logic [hws_pkg::CountW-1:0] loop_q, loop_d;
  logic                       decay_done_q, decay_done_d;
  logic                       halted_q, halted_d;

  logic [hws_pkg::ClockW-1:0] since;
  logic [hws_pkg::ClockW-1:0] uptime;
  logic [hws_pkg::CountW-1:0] loop_inc;
  hws_pkg::result_t           res;

  always_comb begin
    clock_d      = clock_q + {{(hws_pkg::ClockW-hws_pkg::ElapsedW){1'b0}}, item_i.elapsed_ms};
    boot_time_d  = boot_time_q;
    progress_d   = progress_q;
    hb_count_d   = hb_count_q;
    seen_hb_d    = seen_hb_q;
    loop_d       = loop_q;
    decay_done_d = decay_done_q;
    halted_d     = halted_q;
    loop_inc     = (loop_q == hws_pkg::CountMax) ? loop_q : loop_q + 8'd1;
    uptime       = clock_d - boot_time_q;
    since        = '0;
    res          = '0;

    case (item_i.cmd)
      hws_pkg::CMD_BOOT: begin
        // restart the run; a watchdog reset bumps the boot-loop count, others clear it
        loop_d       = item_i.watchdog_caused ? loop_inc : '0;
        boot_time_d  = clock_d;
        progress_d   = clock_d;
        seen_hb_d    = hb_count_q;
        decay_done_d = 1'b0;
        halted_d     = 1'b0;
        if (item_i.watchdog_caused && (loop_d >= cfg_i.max_resets)) begin
          res.boot_loop_trip = 1'b1;
          halted_d           = 1'b1;
        end
      end
      hws_pkg::CMD_HEARTBEAT: begin
        hb_count_d = hb_count_q + 32'd1;
      end
      hws_pkg::CMD_RESET_REQ: begin
        loop_d = '0;
        if (cfg_i.watchdog_enabled) begin
          halted_d = 1'b1;
        end else begin
          res.direct_reboot = 1'b1;
        end
      end
      default: begin
        if (!halted_q) begin
          if (hb_count_q != seen_hb_q) begin
            seen_hb_d  = hb_count_q;
            progress_d = clock_d;
          end
          if (!decay_done_q && (uptime >= cfg_i.uptime_clear_ms)) begin
            loop_d            = '0;
            decay_done_d      = 1'b1;
            res.count_cleared = 1'b1;
          end
          since = clock_d - progress_d;
          if (since >= {{(hws_pkg::ClockW-hws_pkg::DeadlineW){1'b0}},
                        cfg_i.stall_deadline_ms}) begin
            res.stall_detected = 1'b1;
            res.stalled_for_ms = since;
            halted_d           = 1'b1;
          end else begin
            res.pet = 1'b1;
          end
        end
      end
    endcase

    res.stopped    = halted_d;
    res.boot_count = loop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q      <= '0;
      boot_time_q  <= '0;
      progress_q   <= '0;
      hb_count_q   <= '0;
      seen_hb_q    <= '0;
      loop_q       <= '0;
      decay_done_q <= 1'b0;
      halted_q     <= 1'b0;
    end else if (fire_i) begin
      clock_q      <= clock_d;
      boot_time_q  <= boot_time_d;
      progress_q   <= progress_d;
      hb_count_q   <= hb_count_d;
      seen_hb_q    <= seen_hb_d;
      loop_q       <= loop_d;
      decay_done_q <= decay_done_d;
      halted_q     <= halted_d;
    end
  end

  assign result_o = res;

endmodule

@@ rtl/hws_out_reg.sv @@
// ----------------------------------------------------------------------------
// hws_out_reg
// Result register; holds a finished result until downstream takes it.
// ----------------------------------------------------------------------------
module hws_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  hws_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hws_pkg::result_t result_o
);

  logic             valid_q;
  hws_pkg::result_t result_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && fire_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ rtl/heartbeat_watchdog_supervisor_unit.sv @@
// ----------------------------------------------------------------------------
// heartbeat_watchdog_supervisor_unit
// Heartbeat watchdog supervisor: boot-loop counting, stall detection, petting.
// ----------------------------------------------------------------------------
// Path: an accepted event is loaded into the input register, then evaluated and
//   loaded into the result register once that register has room.
// Throughput: 1 event per cycle while the result channel is not stalled; the supervision state updates in one pass.
// Reset: rst_ni asynchronous, active low; clears all supervision state and
//   loads configuration defaults (deadline 1500, uptime 60000, max 3, enabled).
// ----------------------------------------------------------------------------
module heartbeat_watchdog_supervisor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [hws_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hws_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // event channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [hws_pkg::ElapsedW-1:0]  elapsed_ms_i,
  input  logic                          watchdog_caused_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pet_o,
  output logic                          stall_detected_o,
  output logic [hws_pkg::ClockW-1:0]    stalled_for_ms_o,
  output logic                          stopped_o,
  output logic [hws_pkg::CountW-1:0]    boot_count_o,
  output logic                          boot_loop_trip_o,
  output logic                          count_cleared_o,
  output logic                          direct_reboot_o
);

  hws_pkg::cfg_t    cfg;
  hws_pkg::item_t   in_item;
  hws_pkg::item_t   item;
  hws_pkg::result_t core_res;
  hws_pkg::result_t out_res;
  logic             item_valid;
  logic             out_free;
  logic             fire;

  // Pack the event fields
  assign in_item.cmd             = hws_pkg::cmd_e'(cmd_i);
  assign in_item.elapsed_ms      = elapsed_ms_i;
  assign in_item.watchdog_caused = watchdog_caused_i;

  // Evaluate the held event whenever the result register can take it
  assign fire = item_valid && out_free;

  hws_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hws_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item),
    .in_stall_o   (in_stall_o),
    .take_i       (out_free),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  hws_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (core_res)
  );

  hws_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  // Unpack the result fields
  assign pet_o            = out_res.pet;
  assign stall_detected_o = out_res.stall_detected;
  assign stalled_for_ms_o = out_res.stalled_for_ms;
  assign stopped_o        = out_res.stopped;
  assign boot_count_o     = out_res.boot_count;
  assign boot_loop_trip_o = out_res.boot_loop_trip;
  assign count_cleared_o  = out_res.count_cleared;
  assign direct_reboot_o  = out_res.direct_reboot;

  // Input side stalls only when both stages are full and the output is stalled
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register had room");

  // A stall declaration or a trip always leaves petting stopped
  a_stall_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (stall_detected_o || boot_loop_trip_o)) |-> (stopped_o && !pet_o))
    else $error("stall or trip reported without stopping");

  // A healthy-uptime clear leaves the boot-loop count at zero
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && count_cleared_o) |-> (boot_count_o == '0))
    else $error("count cleared but boot count nonzero");

  // A result that is not taken holds for the next cycle
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res)))
    else $error("stalled result changed");

endmodule

@@ test/supervisor_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// Supervisor scoreboard
// Tracks the supervision state of the heartbeat watchdog supervisor, predicts
// one verdict per accepted event and compares it with what the block returns.
// ----------------------------------------------------------------------------
package supervisor_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import hws_pkg::*;

  class supervisor_scoreboard;
    localparam int MaxReports = 40;

    // configuration copy
    logic [DeadlineW-1:0] deadline_ms;
    logic [ClockW-1:0]    uptime_ms;
    logic [CountW-1:0]    max_loops;
    logic                 wdog_on;

    // supervision state
    logic [ClockW-1:0] now_ms;
    logic [ClockW-1:0] boot_at_ms;
    logic [ClockW-1:0] progress_at_ms;
    logic [ClockW-1:0] beats;
    logic [ClockW-1:0] beats_seen;
    logic [CountW-1:0] loop_cnt;
    logic              decayed;
    logic              halted;

    result_t pending_verdicts[$];

    int unsigned errors;
    int unsigned reports;
    int unsigned results_seen;
    int unsigned events_by_cmd[4];
    int unsigned stalls, trips, clears, reboots, pets;

    function new();
      deadline_ms    = StallDeadlineRst;
      uptime_ms      = HealthyUptimeRst;
      max_loops      = MaxResetsRst;
      wdog_on        = WdogEnabledRst;
      now_ms         = '0;
      boot_at_ms     = '0;
      progress_at_ms = '0;
      beats          = '0;
      beats_seen     = '0;
      loop_cnt       = '0;
      decayed        = 1'b0;
      halted         = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_STALL_DEADLINE: deadline_ms = data[DeadlineW-1:0];
        CFG_HEALTHY_UPTIME: uptime_ms   = data[ClockW-1:0];
        CFG_MAX_RESETS:     max_loops   = data[CountW-1:0];
        CFG_WDOG_ENABLED:   wdog_on     = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    // Advance the supervision state by one event and queue its verdict.
    function void note_event(cmd_e cmd, logic [ElapsedW-1:0] elapsed, logic wd_cause);
      result_t v;
      logic [ClockW-1:0] up_ms;
      logic [ClockW-1:0] since_ms;
      v = '0;
      now_ms = now_ms + ClockW'(elapsed);
      events_by_cmd[cmd]++;
      case (cmd)
        CMD_BOOT: begin
          if (wd_cause) begin
            if (loop_cnt != CountMax) loop_cnt = loop_cnt + CountW'(1);
          end else begin
            loop_cnt = '0;
          end
          boot_at_ms     = now_ms;
          progress_at_ms = now_ms;
          beats_seen     = beats;
          decayed        = 1'b0;
          halted         = 1'b0;
          if (wd_cause && loop_cnt >= max_loops) begin
            v.boot_loop_trip = 1'b1;
            halted           = 1'b1;
          end
        end
        CMD_HEARTBEAT: beats = beats + ClockW'(1);
        CMD_RESET_REQ: begin
          loop_cnt = '0;
          if (wdog_on) halted = 1'b1;
          else v.direct_reboot = 1'b1;
        end
        default: begin
          if (!halted) begin
            if (beats != beats_seen) begin
              beats_seen     = beats;
              progress_at_ms = now_ms;
            end
            up_ms = now_ms - boot_at_ms;
            if (!decayed && up_ms >= uptime_ms) begin
              loop_cnt        = '0;
              decayed         = 1'b1;
              v.count_cleared = 1'b1;
            end
            since_ms = now_ms - progress_at_ms;
            if (since_ms >= ClockW'(deadline_ms)) begin
              v.stall_detected = 1'b1;
              v.stalled_for_ms = since_ms;
              halted           = 1'b1;
            end else begin
              v.pet = 1'b1;
            end
          end
        end
      endcase
      v.stopped    = halted;
      v.boot_count = loop_cnt;
      stalls  += v.stall_detected;
      trips   += v.boot_loop_trip;
      clears  += v.count_cleared;
      reboots += v.direct_reboot;
      pets    += v.pet;
      pending_verdicts.push_back(v);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (reports < MaxReports) begin
        $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        reports++;
        if (reports == MaxReports) $display("further mismatch reports suppressed");
      end
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) flag(what, want, got);
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        flag("unexpected result, boot_count", '0, 32'(got.boot_count));
        return;
      end
      want = pending_verdicts.pop_front();
      cmp("pet",            32'(want.pet),            32'(got.pet));
      cmp("stall_detected", 32'(want.stall_detected), 32'(got.stall_detected));
      cmp("stalled_for_ms", want.stalled_for_ms,      got.stalled_for_ms);
      cmp("stopped",        32'(want.stopped),        32'(got.stopped));
      cmp("boot_count",     32'(want.boot_count),     32'(got.boot_count));
      cmp("boot_loop_trip", 32'(want.boot_loop_trip), 32'(got.boot_loop_trip));
      cmp("count_cleared",  32'(want.count_cleared),  32'(got.count_cleared));
      cmp("direct_reboot",  32'(want.direct_reboot),  32'(got.direct_reboot));
    endfunction
  endclass

endpackage

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog supervisor testbench
// Drives boot, heartbeat, check and reset-request transactions into the unit,
// predicts every verdict in a scoreboard and compares field by field. Runs a
// directed part, a boot-loop saturation run and four random phases with
// different idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hws_pkg::*;
  import supervisor_scoreboard_pkg::*;

  localparam int QuietLimit  = 4000;   // cycles without any transaction
  localparam int PhaseEvents = 80;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          cmd_i;
  logic [ElapsedW-1:0] elapsed_ms_i;
  logic                watchdog_caused_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                pet_o;
  logic                stall_detected_o;
  logic [ClockW-1:0]   stalled_for_ms_o;
  logic                stopped_o;
  logic [CountW-1:0]   boot_count_o;
  logic                boot_loop_trip_o;
  logic                count_cleared_o;
  logic                direct_reboot_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  result_t     verdict;

  supervisor_scoreboard sb = new();

  heartbeat_watchdog_supervisor_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .elapsed_ms_i      (elapsed_ms_i),
    .watchdog_caused_i (watchdog_caused_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pet_o             (pet_o),
    .stall_detected_o  (stall_detected_o),
    .stalled_for_ms_o  (stalled_for_ms_o),
    .stopped_o         (stopped_o),
    .boot_count_o      (boot_count_o),
    .boot_loop_trip_o  (boot_loop_trip_o),
    .count_cleared_o   (count_cleared_o),
    .direct_reboot_o   (direct_reboot_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver side: decide the stall for the coming edge at each falling edge.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  // Sample both channels at the rising edge. Inputs are noted first so that
  // a verdict is always queued before its result can show up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_event(cmd_e'(cmd_i), elapsed_ms_i, watchdog_caused_i);
      end
      if (out_valid_o && !out_stall_i) begin
        verdict.pet            = pet_o;
        verdict.stall_detected = stall_detected_o;
        verdict.stalled_for_ms = stalled_for_ms_o;
        verdict.stopped        = stopped_o;
        verdict.boot_count     = boot_count_o;
        verdict.boot_loop_trip = boot_loop_trip_o;
        verdict.count_cleared  = count_cleared_o;
        verdict.direct_reboot  = direct_reboot_o;
        sb.check_verdict(verdict);
      end
      // Watchdog: a long stretch with no transaction on either side means a hang.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Present one event and hold it until the block takes it. The sender may
  // idle first; valid stays high across back-to-back transactions.
  task automatic send_event(cmd_e cmd, logic [ElapsedW-1:0] elapsed, logic wd_cause);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    cmd_i             = cmd;
    elapsed_ms_i      = elapsed;
    watchdog_caused_i = wd_cause;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every queued verdict has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Some very short steps, mostly steps up to just past the default deadline, some over the full range.
  function automatic logic [ElapsedW-1:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return ElapsedW'($urandom_range(3));
    if (r < 7) return ElapsedW'($urandom_range(1600));
    return ElapsedW'($urandom);
  endfunction

  task automatic send_random_event();
    int unsigned r;
    cmd_e cmd;
    r = $urandom_range(99);
    if (r < 45)      cmd = CMD_CHECK;
    else if (r < 75) cmd = CMD_HEARTBEAT;
    else if (r < 88) cmd = CMD_BOOT;
    else             cmd = CMD_RESET_REQ;
    send_event(cmd, pick_elapsed(), ($urandom_range(99) < 65));
  endtask

  // Write all four registers for a random phase; in the default case, upper data
  // bits of the narrow registers carry junk the block must ignore.
  task automatic cfg_phase(int unsigned phase);
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    case (phase)
      0: begin
        cfg_write(CFG_STALL_DEADLINE, 32'd1);
        cfg_write(CFG_HEALTHY_UPTIME, 32'd0);
        cfg_write(CFG_MAX_RESETS, 32'd1);
        cfg_write(CFG_WDOG_ENABLED, 32'd1);
      end
      1: begin
        cfg_write(CFG_STALL_DEADLINE, 32'h3FFF);
        cfg_write(CFG_HEALTHY_UPTIME, 32'hFFFF_FFFF);
        cfg_write(CFG_MAX_RESETS, 32'd2);
        cfg_write(CFG_WDOG_ENABLED, 32'd1);
      end
      2: begin
        cfg_write(CFG_STALL_DEADLINE, 32'd3000);
        cfg_write(CFG_HEALTHY_UPTIME, 32'd1);
        cfg_write(CFG_MAX_RESETS, 32'd4);
        cfg_write(CFG_WDOG_ENABLED, 32'd0);
      end
      default: begin
        cfg_write(CFG_STALL_DEADLINE, {junk[31:14], 14'($urandom_range(8388, 1))});
        cfg_write(CFG_HEALTHY_UPTIME, 32'($urandom_range(200000, 1000)));
        cfg_write(CFG_MAX_RESETS, {junk[31:8], 8'($urandom_range(8, 1))});
        cfg_write(CFG_WDOG_ENABLED, {junk[31:1], 1'b1});
      end
    endcase
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_STALL_DEADLINE;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    cmd_i             = CMD_CHECK;
    elapsed_ms_i      = '0;
    watchdog_caused_i = 1'b0;
    out_stall_i       = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    quiet_cycles      = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under reset defaults (deadline 1500, uptime 60000, max 3).
    send_event(CMD_CHECK, 16'd0, 1'b1);          // check before any boot
    send_event(CMD_HEARTBEAT, 16'hFFFF, 1'b0);
    send_event(CMD_CHECK, 16'd0, 1'b0);          // progress recorded
    send_event(CMD_CHECK, 16'd1499, 1'b0);       // one short of the deadline
    send_event(CMD_CHECK, 16'd1, 1'b0);          // deadline reached: stall
    send_event(CMD_CHECK, 16'd7, 1'b1);          // halted: nothing moves
    send_event(CMD_BOOT, 16'd0, 1'b1);
    send_event(CMD_BOOT, 16'd0, 1'b1);
    send_event(CMD_BOOT, 16'd0, 1'b1);           // third watchdog boot trips
    send_event(CMD_CHECK, 16'd3, 1'b0);
    send_event(CMD_BOOT, 16'd0, 1'b0);           // clean boot clears the count
    send_event(CMD_BOOT, 16'd100, 1'b1);
    send_event(CMD_HEARTBEAT, 16'd30000, 1'b1);
    send_event(CMD_CHECK, 16'd30000, 1'b0);      // healthy uptime clears once
    send_event(CMD_CHECK, 16'd5, 1'b0);
    send_event(CMD_RESET_REQ, 16'd2, 1'b0);      // watchdog on: stop at once
    send_event(CMD_CHECK, 16'd0, 1'b0);
    send_event(CMD_RESET_REQ, 16'd0, 1'b1);
    drain();
    cfg_write(CFG_WDOG_ENABLED, 32'd0);
    send_event(CMD_RESET_REQ, 16'd9, 1'b0);      // watchdog off: direct reboot
    send_event(CMD_BOOT, 16'd0, 1'b0);
    drain();
    cfg_write(CFG_STALL_DEADLINE, 32'd0);
    cfg_write(CFG_MAX_RESETS, 32'd0);
    send_event(CMD_CHECK, 16'd0, 1'b0);          // zero deadline: stall at once
    send_event(CMD_BOOT, 16'd1, 1'b1);           // zero limit: every watchdog boot trips
    send_event(CMD_BOOT, 16'd1, 1'b0);
    send_event(CMD_CHECK, 16'd0, 1'b0);
    drain();

    // Boot-loop saturation: run the count past its top value.
    cfg_write(CFG_MAX_RESETS, 32'd255);
    cfg_write(CFG_STALL_DEADLINE, 32'h3FFF);
    cfg_write(CFG_WDOG_ENABLED, 32'd1);
    recv_stall_pct = 20;
    for (int i = 0; i < 258; i++) begin
      send_event(CMD_BOOT, pick_elapsed(), 1'b1);
    end
    drain();

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      cfg_phase(phase);
      send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 38 : 0;
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 38 : 0;
      for (int i = 0; i < PhaseEvents; i++) begin
        if (i == PhaseEvents / 2) drain();   // let the pipeline run empty once
        send_random_event();
      end
      drain();
    end

    // Trailing window: catch any stray result after the last verdict.
    repeat (8) @(posedge clk_i);
    $display("covered %0d checks, %0d heartbeats, %0d reset requests, %0d boots; %0d results",
             sb.events_by_cmd[CMD_CHECK], sb.events_by_cmd[CMD_HEARTBEAT],
             sb.events_by_cmd[CMD_RESET_REQ], sb.events_by_cmd[CMD_BOOT], sb.results_seen);
    $display("verdicts seen: %0d pets, %0d stalls, %0d trips, %0d count clears, %0d reboots",
             sb.pets, sb.stalls, sb.trips, sb.clears, sb.reboots);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hws_pkg.sv
rtl/hws_cfg_regs.sv
rtl/hws_in_reg.sv
rtl/hws_core.sv
rtl/hws_out_reg.sv
rtl/heartbeat_watchdog_supervisor_unit.sv
test/supervisor_scoreboard_pkg.sv
test/tb.sv
